### rtl/core/association_hypothesis_enumerator_assert.svh
// Assertion macros shared by the association hypothesis enumerator RTL.
`ifndef ASSOCIATION_HYPOTHESIS_ENUMERATOR_ASSERT_SVH
`define ASSOCIATION_HYPOTHESIS_ENUMERATOR_ASSERT_SVH

// Check that a condition implies another in the same cycle.
`define AHE_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that a condition implies another in the next cycle.
`define AHE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/core/ahe_pkg.sv
// Constants, codes and types of the association hypothesis enumerator.
package ahe_pkg;

	localparam int MAX_MEAS   = 16;
	localparam int MAX_TRACKS = 16;
	localparam int MAX_HYP    = 1024;

	localparam int MEAS_W  = 4;
	localparam int TRK_W   = 4;
	localparam int ROW_W   = 16;
	localparam int HYP_W   = 11;
	localparam int CNT_W   = $clog2(MAX_MEAS + 1);
	localparam int TPOS_W  = $clog2(ROW_W + 1);
	localparam int TRK_LIM = (MAX_TRACKS < ROW_W) ? MAX_TRACKS : ROW_W;

	localparam logic [ROW_W-1:0] TRK_MASK = ROW_W'((17'd1 << TRK_LIM) - 17'd1);

	localparam logic [1:0] OP_LOAD  = 2'd0;
	localparam logic [1:0] OP_FETCH = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;

	localparam logic [2:0] STS_LOADED  = 3'd0;
	localparam logic [2:0] STS_HYP     = 3'd1;
	localparam logic [2:0] STS_CLUTTER = 3'd2;
	localparam logic [2:0] STS_DONE    = 3'd3;
	localparam logic [2:0] STS_OVF     = 3'd4;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_CHECK,
		ST_EMIT
	} fsm_t;

	typedef enum logic [1:0] {
		PH_SINGLE,
		PH_PAIR,
		PH_EXHAUSTED,
		PH_OVERFLOW
	} phase_t;

	typedef struct packed {
		logic             found;
		logic [TRK_W-1:0] idx;
	} pick_t;

	typedef struct packed {
		logic [2:0]        status;
		logic [1:0]        assoc_count;
		logic [MEAS_W-1:0] first_meas;
		logic [TRK_W-1:0]  first_track;
		logic [MEAS_W-1:0] second_meas;
		logic [TRK_W-1:0]  second_track;
		logic [HYP_W-1:0]  hyp_number;
	} res_t;

endpackage

### rtl/core/ahe_pick.sv
// Lowest gated track at or above a start position in one gating row.
module ahe_pick (
	input  logic [ahe_pkg::ROW_W-1:0]  row,
	input  logic [ahe_pkg::TPOS_W-1:0] start,
	output ahe_pkg::pick_t             pick
);

	logic [ahe_pkg::ROW_W-1:0] masked;

	assign masked = row & ahe_pkg::TRK_MASK & ({ahe_pkg::ROW_W{1'b1}} << start);

	always_comb begin
		pick.found = |masked;
		pick.idx   = '0;
		for (int k = ahe_pkg::ROW_W - 1; k >= 0; k--) begin
			if (masked[k]) begin
				pick.idx = ahe_pkg::TRK_W'(k);
			end
		end
	end

endmodule

### rtl/core/association_hypothesis_enumerator.sv
// Top level: gating row memory, hypothesis scan sequencer and result register.
//
//  channel | direction | handshake              | fields
//  req     | in        | req_valid / req_stall  | opcode, meas_index, track_mask, last_row
//  rsp     | out       | rsp_valid / rsp_stall  | status, assoc_count, first/second_*, hyp_number
//
// Load, clear, unused opcodes and a fetch after exhaustion or overflow go from IDLE straight to EMIT;
// no new item is taken until the result leaves res_q for the output register. Other fetches move
// between READ, which reads one row, and CHECK, which priority-encodes it; READ also skips a pair's
// outer row or finds the rows ended. Reset clears the sequencer, the enumeration position and the
// row count; the row memory holds nothing defined until loaded. A new item is taken while the
// previous result waits in the output register; a stalled output holds the sequencer in EMIT.
module association_hypothesis_enumerator (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        req_valid,
	output logic                        req_stall,
	input  logic [1:0]                  opcode,
	input  logic [ahe_pkg::MEAS_W-1:0]  meas_index,
	input  logic [ahe_pkg::ROW_W-1:0]   track_mask,
	input  logic                        last_row,
	output logic                        rsp_valid,
	input  logic                        rsp_stall,
	output logic [2:0]                  status,
	output logic [1:0]                  assoc_count,
	output logic [ahe_pkg::MEAS_W-1:0]  first_meas,
	output logic [ahe_pkg::TRK_W-1:0]   first_track,
	output logic [ahe_pkg::MEAS_W-1:0]  second_meas,
	output logic [ahe_pkg::TRK_W-1:0]   second_track,
	output logic [ahe_pkg::HYP_W-1:0]   hyp_number
);

	logic [ahe_pkg::ROW_W-1:0]  gate_rows_q [ahe_pkg::MAX_MEAS];
	logic [ahe_pkg::ROW_W-1:0]  rd_data_q;

	ahe_pkg::fsm_t              state_q, state_d;
	ahe_pkg::phase_t            phase_q, phase_d;
	logic                       pair_scan_q, pair_scan_d;
	logic [ahe_pkg::CNT_W-1:0]  meas_count_q, meas_count_d;
	logic [ahe_pkg::CNT_W-1:0]  scan_row_q, scan_row_d;
	logic [ahe_pkg::MEAS_W-1:0] outer_meas_q, outer_meas_d;
	logic [ahe_pkg::TPOS_W-1:0] outer_track_q, outer_track_d;
	logic [ahe_pkg::MEAS_W-1:0] inner_meas_q, inner_meas_d;
	logic [ahe_pkg::TPOS_W-1:0] inner_track_q, inner_track_d;
	logic [ahe_pkg::HYP_W-1:0]  hyp_counter_q, hyp_counter_d;
	ahe_pkg::res_t              res_q, res_d;
	ahe_pkg::res_t              out_q;
	logic                       rsp_valid_q;

	logic                       mem_we;
	logic                       emit;
	ahe_pkg::res_t              cand;
	logic [ahe_pkg::TPOS_W-1:0] pick_start;
	logic [ahe_pkg::TPOS_W-1:0] pair_base;
	ahe_pkg::pick_t             pick;
	logic                       out_load;

	assign req_stall = (state_q != ahe_pkg::ST_IDLE);
	assign out_load  = (state_q == ahe_pkg::ST_EMIT) && (!rsp_valid_q || !rsp_stall);

	always_ff @(posedge clk) begin
		if (mem_we) begin
			gate_rows_q[meas_index] <= track_mask;
		end
		rd_data_q <= gate_rows_q[scan_row_q[ahe_pkg::MEAS_W-1:0]];
	end

	assign pair_base = outer_track_q + ahe_pkg::TPOS_W'(1);

	always_comb begin
		if (pair_scan_q) begin
			pick_start = pair_base;
			if (scan_row_q == {1'b0, inner_meas_q} && inner_track_q > pair_base) begin
				pick_start = inner_track_q;
			end
		end else if (scan_row_q == {1'b0, outer_meas_q}) begin
			pick_start = outer_track_q;
		end else begin
			pick_start = '0;
		end
	end

	ahe_pick u_pick (
		.row   (rd_data_q),
		.start (pick_start),
		.pick  (pick)
	);

	always_comb begin
		state_d       = state_q;
		phase_d       = phase_q;
		pair_scan_d   = pair_scan_q;
		meas_count_d  = meas_count_q;
		scan_row_d    = scan_row_q;
		outer_meas_d  = outer_meas_q;
		outer_track_d = outer_track_q;
		inner_meas_d  = inner_meas_q;
		inner_track_d = inner_track_q;
		hyp_counter_d = hyp_counter_q;
		res_d         = res_q;
		mem_we        = 1'b0;
		emit          = 1'b0;
		cand          = '0;
		case (state_q)
			ahe_pkg::ST_IDLE: begin
				if (req_valid) begin
					res_d        = '0;
					res_d.status = ahe_pkg::STS_LOADED;
					state_d      = ahe_pkg::ST_EMIT;
					case (opcode)
						ahe_pkg::OP_LOAD, ahe_pkg::OP_CLEAR: begin
							if (opcode == ahe_pkg::OP_CLEAR) begin
								meas_count_d = '0;
							end else if ({1'b0, meas_index} <
									ahe_pkg::CNT_W'(ahe_pkg::MAX_MEAS)) begin
								mem_we = 1'b1;
								if (last_row) begin
									meas_count_d = ahe_pkg::CNT_W'(meas_index) +
										ahe_pkg::CNT_W'(1);
								end
							end
							phase_d       = ahe_pkg::PH_SINGLE;
							outer_meas_d  = '0;
							outer_track_d = '0;
							inner_meas_d  = '0;
							inner_track_d = '0;
							hyp_counter_d = '0;
						end
						ahe_pkg::OP_FETCH: begin
							case (phase_q)
								ahe_pkg::PH_OVERFLOW: begin
									res_d.status     = ahe_pkg::STS_OVF;
									res_d.hyp_number = hyp_counter_q;
								end
								ahe_pkg::PH_EXHAUSTED: begin
									res_d.status     = ahe_pkg::STS_DONE;
									res_d.hyp_number = hyp_counter_q;
								end
								ahe_pkg::PH_PAIR: begin
									scan_row_d  = {1'b0, inner_meas_q};
									pair_scan_d = 1'b1;
									state_d     = ahe_pkg::ST_READ;
								end
								default: begin
									scan_row_d  = {1'b0, outer_meas_q};
									pair_scan_d = 1'b0;
									state_d     = ahe_pkg::ST_READ;
								end
							endcase
						end
						default: begin
							res_d.status = ahe_pkg::STS_LOADED;
						end
					endcase
				end
			end
			ahe_pkg::ST_READ: begin
				if (scan_row_q >= meas_count_q) begin
					if (pair_scan_q) begin
						outer_track_d = outer_track_q + ahe_pkg::TPOS_W'(1);
						phase_d       = ahe_pkg::PH_SINGLE;
						pair_scan_d   = 1'b0;
						scan_row_d    = {1'b0, outer_meas_q};
					end else begin
						phase_d     = ahe_pkg::PH_EXHAUSTED;
						emit        = 1'b1;
						cand.status = ahe_pkg::STS_CLUTTER;
						state_d     = ahe_pkg::ST_EMIT;
					end
				end else if (pair_scan_q && scan_row_q == {1'b0, outer_meas_q}) begin
					scan_row_d = scan_row_q + ahe_pkg::CNT_W'(1);
				end else begin
					state_d = ahe_pkg::ST_CHECK;
				end
			end
			ahe_pkg::ST_CHECK: begin
				if (pick.found) begin
					emit        = 1'b1;
					cand.status = ahe_pkg::STS_HYP;
					state_d     = ahe_pkg::ST_EMIT;
					if (pair_scan_q) begin
						inner_meas_d      = scan_row_q[ahe_pkg::MEAS_W-1:0];
						inner_track_d     = {1'b0, pick.idx} + ahe_pkg::TPOS_W'(1);
						cand.assoc_count  = 2'd2;
						cand.first_meas   = outer_meas_q;
						cand.first_track  = outer_track_q[ahe_pkg::TRK_W-1:0];
						cand.second_meas  = scan_row_q[ahe_pkg::MEAS_W-1:0];
						cand.second_track = pick.idx;
					end else begin
						outer_meas_d     = scan_row_q[ahe_pkg::MEAS_W-1:0];
						outer_track_d    = {1'b0, pick.idx};
						inner_meas_d     = '0;
						inner_track_d    = {1'b0, pick.idx} + ahe_pkg::TPOS_W'(1);
						phase_d          = ahe_pkg::PH_PAIR;
						cand.assoc_count = 2'd1;
						cand.first_meas  = scan_row_q[ahe_pkg::MEAS_W-1:0];
						cand.first_track = pick.idx;
					end
				end else begin
					scan_row_d = scan_row_q + ahe_pkg::CNT_W'(1);
					state_d    = ahe_pkg::ST_READ;
				end
			end
			ahe_pkg::ST_EMIT: begin
				if (out_load) begin
					state_d = ahe_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = ahe_pkg::ST_IDLE;
			end
		endcase
		if (emit) begin
			if (hyp_counter_q >= ahe_pkg::HYP_W'(ahe_pkg::MAX_HYP)) begin
				phase_d          = ahe_pkg::PH_OVERFLOW;
				res_d            = '0;
				res_d.status     = ahe_pkg::STS_OVF;
				res_d.hyp_number = hyp_counter_q;
			end else begin
				res_d            = cand;
				res_d.hyp_number = hyp_counter_q;
				hyp_counter_d    = hyp_counter_q + ahe_pkg::HYP_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ahe_pkg::ST_IDLE;
			phase_q       <= ahe_pkg::PH_SINGLE;
			pair_scan_q   <= 1'b0;
			meas_count_q  <= '0;
			outer_meas_q  <= '0;
			outer_track_q <= '0;
			inner_meas_q  <= '0;
			inner_track_q <= '0;
			hyp_counter_q <= '0;
			rsp_valid_q   <= 1'b0;
		end else begin
			state_q       <= state_d;
			phase_q       <= phase_d;
			pair_scan_q   <= pair_scan_d;
			meas_count_q  <= meas_count_d;
			outer_meas_q  <= outer_meas_d;
			outer_track_q <= outer_track_d;
			inner_meas_q  <= inner_meas_d;
			inner_track_q <= inner_track_d;
			hyp_counter_q <= hyp_counter_d;
			if (out_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		scan_row_q <= scan_row_d;
		res_q      <= res_d;
		if (out_load) begin
			out_q <= res_q;
		end
	end

	assign rsp_valid    = rsp_valid_q;
	assign status       = out_q.status;
	assign assoc_count  = out_q.assoc_count;
	assign first_meas   = out_q.first_meas;
	assign first_track  = out_q.first_track;
	assign second_meas  = out_q.second_meas;
	assign second_track = out_q.second_track;
	assign hyp_number   = out_q.hyp_number;

`include "association_hypothesis_enumerator_assert.svh"

	`AHE_ASSERT_SAME(a_check_in_range, state_q == ahe_pkg::ST_CHECK,
		scan_row_q < meas_count_q, "row check beyond loaded rows")
	`AHE_ASSERT_SAME(a_ovf_count, phase_q == ahe_pkg::PH_OVERFLOW,
		hyp_counter_q == ahe_pkg::HYP_W'(ahe_pkg::MAX_HYP), "overflow without full count")
	`AHE_ASSERT_SAME(a_pair_order,
		rsp_valid && status == ahe_pkg::STS_HYP && assoc_count == 2'd2,
		second_track > first_track && second_meas != first_meas, "bad pairing order")
	`AHE_ASSERT_NEXT(a_count_grows, state_q != ahe_pkg::ST_IDLE,
		hyp_counter_q >= $past(hyp_counter_q), "hypothesis count fell during a fetch")

endmodule

### test/tb.sv
// Testbench for the hypothesis enumerator: directed, random and overflow runs, scoreboard check.
module tb;

	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int unsigned CYCLE_LIMIT = 3000000;
	localparam int PHASE_ITEMS = 80;

	class hyp_scoreboard;
		logic [ahe_pkg::ROW_W-1:0] rows [ahe_pkg::MAX_MEAS];
		int meas_cnt;
		int om, ot, im, it;
		ahe_pkg::phase_t phase;
		int hyp_cnt;
		ahe_pkg::res_t expected_hyps [$];
		int errors;

		function new();
			int k;
			for (k = 0; k < ahe_pkg::MAX_MEAS; k++)
				rows[k] = '0;
			meas_cnt = 0;
			errors = 0;
			restart();
		endfunction

		function void restart();
			om = 0;
			ot = 0;
			im = 0;
			it = 0;
			phase = ahe_pkg::PH_SINGLE;
			hyp_cnt = 0;
		endfunction

		function bit gate_bit(int r, int t);
			if (r >= meas_cnt || r >= ahe_pkg::MAX_MEAS || t >= ahe_pkg::TRK_LIM)
				return 1'b0;
			return rows[r][t];
		endfunction

		function bit find_single();
			int i, j;
			for (i = om; i < meas_cnt; i++) begin
				for (j = (i == om) ? ot : 0; j < ahe_pkg::TRK_LIM; j++) begin
					if (gate_bit(i, j)) begin
						om = i;
						ot = j;
						return 1'b1;
					end
				end
			end
			return 1'b0;
		endfunction

		function bit find_pair(output int lm, output int mm);
			int l, m, start;
			lm = 0;
			mm = 0;
			for (l = im; l < meas_cnt; l++) begin
				if (l == om)
					continue;
				start = ot + 1;
				if (l == im && it > start)
					start = it;
				for (m = start; m < ahe_pkg::TRK_LIM; m++) begin
					if (gate_bit(l, m)) begin
						im = l;
						it = m + 1;
						lm = l;
						mm = m;
						return 1'b1;
					end
				end
			end
			return 1'b0;
		endfunction

		function ahe_pkg::res_t emit_hyp(logic [2:0] st, int cnt, int m1, int t1, int m2,
			int t2);
			ahe_pkg::res_t r;
			r = '0;
			r.hyp_number = ahe_pkg::HYP_W'(hyp_cnt);
			if (hyp_cnt >= ahe_pkg::MAX_HYP) begin
				phase = ahe_pkg::PH_OVERFLOW;
				r.status = ahe_pkg::STS_OVF;
				return r;
			end
			r.status = st;
			r.assoc_count = 2'(cnt);
			r.first_meas = ahe_pkg::MEAS_W'(m1);
			r.first_track = ahe_pkg::TRK_W'(t1);
			r.second_meas = ahe_pkg::MEAS_W'(m2);
			r.second_track = ahe_pkg::TRK_W'(t2);
			hyp_cnt++;
			return r;
		endfunction

		function ahe_pkg::res_t predict_hyp(logic [1:0] op, logic [3:0] idx,
			logic [15:0] mask, logic last);
			ahe_pkg::res_t r;
			int k, lm, mm;
			bit done;
			r = '0;
			case (op)
				ahe_pkg::OP_LOAD: begin
					rows[idx] = mask;
					if (last)
						meas_cnt = idx + 1;
					restart();
				end
				ahe_pkg::OP_CLEAR: begin
					meas_cnt = 0;
					restart();
				end
				ahe_pkg::OP_FETCH: begin
					done = 1'b0;
					for (k = 0; k < 3 && !done; k++) begin
						if (phase == ahe_pkg::PH_OVERFLOW) begin
							r.status = ahe_pkg::STS_OVF;
							r.hyp_number = ahe_pkg::HYP_W'(hyp_cnt);
							done = 1'b1;
						end else if (phase == ahe_pkg::PH_EXHAUSTED) begin
							r.status = ahe_pkg::STS_DONE;
							r.hyp_number = ahe_pkg::HYP_W'(hyp_cnt);
							done = 1'b1;
						end else if (phase == ahe_pkg::PH_SINGLE) begin
							if (find_single()) begin
								im = 0;
								it = ot + 1;
								phase = ahe_pkg::PH_PAIR;
								r = emit_hyp(ahe_pkg::STS_HYP, 1, om, ot, 0, 0);
							end else begin
								phase = ahe_pkg::PH_EXHAUSTED;
								r = emit_hyp(ahe_pkg::STS_CLUTTER, 0, 0, 0, 0, 0);
							end
							done = 1'b1;
						end else if (find_pair(lm, mm)) begin
							r = emit_hyp(ahe_pkg::STS_HYP, 2, om, ot, lm, mm);
							done = 1'b1;
						end else begin
							ot++;
							phase = ahe_pkg::PH_SINGLE;
						end
					end
				end
				default: ;
			endcase
			return r;
		endfunction

		function void note_request(logic [1:0] op, logic [3:0] idx, logic [15:0] mask,
			logic last);
			expected_hyps.push_back(predict_hyp(op, idx, mask, last));
		endfunction

		function void compare(string field, logic [15:0] want, logic [15:0] got);
			if (got !== want) begin
				$error("%s: expected %0d, actual %0d", field, want, got);
				errors++;
			end
		endfunction

		function void check_response(ahe_pkg::res_t got);
			ahe_pkg::res_t want;
			if (expected_hyps.size() == 0) begin
				$error("status: expected none, actual %0d", got.status);
				errors++;
				return;
			end
			want = expected_hyps.pop_front();
			compare("status", 16'(want.status), 16'(got.status));
			compare("assoc_count", 16'(want.assoc_count), 16'(got.assoc_count));
			compare("first_meas", 16'(want.first_meas), 16'(got.first_meas));
			compare("first_track", 16'(want.first_track), 16'(got.first_track));
			compare("second_meas", 16'(want.second_meas), 16'(got.second_meas));
			compare("second_track", 16'(want.second_track), 16'(got.second_track));
			compare("hyp_number", 16'(want.hyp_number), 16'(got.hyp_number));
		endfunction

		function int pending();
			return expected_hyps.size();
		endfunction

		function ahe_pkg::phase_t enum_phase();
			return phase;
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	logic [1:0] opcode = '0;
	logic [ahe_pkg::MEAS_W-1:0] meas_index = '0;
	logic [ahe_pkg::ROW_W-1:0] track_mask = '0;
	logic last_row = 1'b0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	logic [2:0] status;
	logic [1:0] assoc_count;
	logic [ahe_pkg::MEAS_W-1:0] first_meas;
	logic [ahe_pkg::TRK_W-1:0] first_track;
	logic [ahe_pkg::MEAS_W-1:0] second_meas;
	logic [ahe_pkg::TRK_W-1:0] second_track;
	logic [ahe_pkg::HYP_W-1:0] hyp_number;

	hyp_scoreboard sb;
	bit row_loaded [ahe_pkg::MAX_MEAS];
	int snd_idle = 11;
	int rcv_stall = 71;
	int sent_items = 0;
	int unsigned cycle_cnt = 0;

	association_hypothesis_enumerator i_dut (.*);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("association_hypothesis_enumerator verification failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (rsp_valid === 1'b1 && !rsp_stall)
			sb.check_response({status, assoc_count, first_meas, first_track, second_meas,
				second_track, hyp_number});
		rsp_stall <= ($urandom_range(99) < rcv_stall);
	end

	task automatic send_req(input logic [1:0] op, input logic [3:0] idx,
		input logic [15:0] mask, input logic last);
		int k;
		while ($urandom_range(99) < snd_idle) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		// drop the count update unless every lower row holds data
		if (op == ahe_pkg::OP_LOAD) begin
			if (last)
				for (k = 0; k < idx; k++)
					if (!row_loaded[k])
						last = 1'b0;
			row_loaded[idx] = 1'b1;
		end
		req_valid <= 1'b1;
		opcode <= op;
		meas_index <= idx;
		track_mask <= mask;
		last_row <= last;
		do @(posedge clk); while (req_stall);
		sb.note_request(op, idx, mask, last);
		if (op != OP_UNUSED)
			sent_items++;
	endtask

	task automatic send_fetch();
		send_req(ahe_pkg::OP_FETCH, 4'($urandom_range(15)), 16'($urandom()),
			1'($urandom_range(1)));
	endtask

	function automatic logic [15:0] gen_mask(int dens);
		case (dens)
			0: return $urandom_range(1) ? 16'(1 << $urandom_range(15)) : 16'h0000;
			1: return 16'($urandom() & $urandom() & $urandom());
			2: return 16'($urandom() & $urandom());
			default: begin
				case ($urandom_range(2))
					0: return 16'hFFFF;
					1: return 16'h0000;
					default: return 16'($urandom());
				endcase
			end
		endcase
	endfunction

	task automatic run_session();
		int n, k, j, tmp, d, dens, cap;
		int order [ahe_pkg::MAX_MEAS];
		if ($urandom_range(9) == 0) begin
			repeat ($urandom_range(1, 8))
				send_req(2'($urandom_range(3)), 4'($urandom_range(15)), 16'($urandom()),
					1'($urandom_range(1)));
			return;
		end
		if ($urandom_range(7) == 0) begin
			send_req(ahe_pkg::OP_CLEAR, 4'($urandom_range(15)), 16'($urandom()),
				1'($urandom_range(1)));
		end else begin
			n = ($urandom_range(9) == 0) ? $urandom_range(6, ahe_pkg::MAX_MEAS) :
				$urandom_range(1, 5);
			d = $urandom_range(9);
			dens = (d < 4) ? 0 : (d < 7) ? 1 : (d < 9) ? 2 : 3;
			if (n > 5)
				dens = 0;
			for (k = 0; k < n - 1; k++)
				order[k] = k;
			for (k = n - 2; k > 0; k--) begin
				j = $urandom_range(k);
				tmp = order[k];
				order[k] = order[j];
				order[j] = tmp;
			end
			for (k = 0; k < n - 1; k++)
				send_req(ahe_pkg::OP_LOAD, 4'(order[k]), gen_mask(dens), 1'($urandom_range(1)));
			send_req(ahe_pkg::OP_LOAD, 4'(n - 1), gen_mask(dens), 1'b1);
			if ($urandom_range(4) == 0)
				send_req(ahe_pkg::OP_LOAD, 4'($urandom_range(n - 1)), gen_mask(dens), 1'b0);
		end
		cap = ($urandom_range(3) == 0) ? $urandom_range(1, 20) : 80;
		while (cap > 0 && sb.enum_phase() != ahe_pkg::PH_EXHAUSTED &&
				sb.enum_phase() != ahe_pkg::PH_OVERFLOW) begin
			send_fetch();
			cap--;
		end
		repeat ($urandom_range(2))
			send_fetch();
	endtask

	task automatic run_overflow();
		int n, k, cap;
		n = $urandom_range(6, 8);
		for (k = 0; k < n; k++)
			send_req(ahe_pkg::OP_LOAD, 4'(k),
				$urandom_range(1) ? 16'hFFFF : ~16'(1 << $urandom_range(15)), k == n - 1);
		cap = ahe_pkg::MAX_HYP + 50;
		while (cap > 0 && sb.enum_phase() != ahe_pkg::PH_OVERFLOW) begin
			send_fetch();
			cap--;
		end
		repeat (2)
			send_fetch();
		send_req(ahe_pkg::OP_CLEAR, 4'd0, 16'h0000, 1'b0);
		send_fetch();
	endtask

	task automatic run_directed();
		send_req(ahe_pkg::OP_FETCH, 4'd0, 16'h0000, 1'b0);
		send_req(ahe_pkg::OP_FETCH, 4'd15, 16'hFFFF, 1'b1);
		send_req(OP_UNUSED, 4'd15, 16'hFFFF, 1'b1);
		send_req(ahe_pkg::OP_FETCH, 4'd0, 16'h0000, 1'b0);
		send_req(ahe_pkg::OP_LOAD, 4'd0, 16'h8001, 1'b0);
		send_req(ahe_pkg::OP_LOAD, 4'd1, 16'hFFFF, 1'b0);
		send_req(ahe_pkg::OP_LOAD, 4'd2, 16'h0000, 1'b1);
		repeat (6)
			send_fetch();
		send_req(ahe_pkg::OP_LOAD, 4'd1, 16'h0002, 1'b0);
		repeat (4)
			send_fetch();
		send_req(ahe_pkg::OP_CLEAR, 4'd0, 16'h0000, 1'b0);
		send_fetch();
		send_fetch();
		send_req(ahe_pkg::OP_LOAD, 4'd0, 16'h0000, 1'b1);
		send_fetch();
		send_req(OP_UNUSED, 4'd0, 16'h0000, 1'b0);
	endtask

	initial begin
		int ph, goal;
		sb = new();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		run_directed();
		for (ph = 0; ph < 3; ph++) begin
			case (ph)
				0: begin snd_idle = 11; rcv_stall = 71; end
				1: begin snd_idle = 71; rcv_stall = 11; end
				default: begin snd_idle = 0; rcv_stall = 0; end
			endcase
			goal = sent_items + PHASE_ITEMS;
			while (sent_items < goal)
				run_session();
			if (ph == 1)
				run_overflow();
		end
		req_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("association_hypothesis_enumerator verification clean");
		else
			$display("association_hypothesis_enumerator verification failed");
		$finish;
	end
endmodule
